FILE: hdl/jse_pkg.sv
// Shared types, constants and helper functions for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

   localparam int JOB_BYTES   = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int HELD_DEPTH  = 3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_TAB = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0a;
   localparam logic [7:0] CTRL_FF  = 8'h0c;
   localparam logic [7:0] CTRL_CR  = 8'h0d;

   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_MASK   = 8'hc0;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'he0;
   localparam logic [7:0] LEAD2_CODE  = 8'hc0;
   localparam logic [7:0] LEAD3_MASK  = 8'hf0;
   localparam logic [7:0] LEAD3_CODE  = 8'he0;
   localparam logic [7:0] LEAD4_MASK  = 8'hf8;
   localparam logic [7:0] LEAD4_CODE  = 8'hf0;
   localparam logic [7:0] BAD_LEAD3   = 8'hed;
   localparam logic [7:0] BAD_LEAD4   = 8'hf4;

   typedef logic [$clog2(JOB_BYTES+1)-1:0] job_count_type;
   typedef logic [$clog2(JOB_BYTES)-1:0]   job_index_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      job_count_type             count;
      logic                      last;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         hex_char = wide + 8'h30;
      end else begin
         hex_char = wide + 8'h37;
      end
   endfunction

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      lead_length = 3'd0;
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         lead_length = 3'd2;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         lead_length = (b == BAD_LEAD3) ? 3'd0 : 3'd3;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         lead_length = (b == BAD_LEAD4) ? 3'd0 : 3'd4;
      end
   endfunction

endpackage

FILE: hdl/json_string_escaper.sv
// Top level of the JSON string escaper: front end, job queue and output sequencer.
// Each accepted input item is turned into a job of up to eight output bytes (opening quote,
// escaped or passed-through body, closing quote marked with rsp_out_last), which waits in a
// two-entry queue; the output sequencer sends one byte per cycle while rsp_ready is high,
// from a registered output. An input item is accepted every cycle while the queue has room,
// so the sustained rate is one item per cycle when each item yields at most one byte and
// rsp_ready stays high; longer items hold the output, and the output sequencer sets the pace.
// Each byte is registered in the queue and then in the output register before rsp_out_byte.
`timescale 1ns / 1ps

module json_string_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic             push_valid, push_ready;
   logic             pop_valid, pop_ready;
   jse_pkg::job_type push_job, pop_job;

   jse_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_string_end   (req_string_end),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   jse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_job      (pop_job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: hdl/jse_front.sv
// Front end: accepts input bytes, tracks string and UTF-8 state, builds output jobs.
`timescale 1ns / 1ps

module jse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic              req_string_end,
   output logic              push_valid,
   input  logic              push_ready,
   output jse_pkg::job_type  push_job
);

   logic       inside_ff, inside_in;
   logic       disc_ff, disc_in;
   logic [1:0] hc_ff, hc_in;
   logic [2:0] sl_ff, sl_in;
   logic [7:0] held_ff [jse_pkg::HELD_DEPTH];

   logic       accept;
   logic       take;
   logic       open_q;
   logic       wr_en;
   logic [1:0] wr_idx;
   logic [7:0] b;
   logic [2:0] lead_n;
   logic [2:0] body_n;
   logic [jse_pkg::JOB_BYTES-1:0][7:0] body;
   jse_pkg::job_type job;

   assign b         = req_data_byte;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign open_q    = !inside_ff;
   assign take      = req_byte_present && !disc_ff;
   assign lead_n    = jse_pkg::lead_length(b);

   always_comb begin
      body   = {jse_pkg::JOB_BYTES{b}};
      body_n = 3'd0;
      hc_in  = hc_ff;
      sl_in  = sl_ff;
      disc_in = disc_ff;
      wr_en  = 1'b0;
      wr_idx = hc_ff;
      if (take) begin
         if (sl_ff != 3'd0) begin
            if ((b & jse_pkg::CONT_MASK) != jse_pkg::CONT_CODE) begin
               hc_in   = 2'd0;
               sl_in   = 3'd0;
               disc_in = 1'b1;
            end else if (({1'b0, hc_ff} + 3'd1) >= sl_ff) begin
               for (int i = 0; i < jse_pkg::HELD_DEPTH; i++) begin
                  if (2'(i) < hc_ff) begin
                     body[i] = held_ff[i];
                  end
               end
               body_n = {1'b0, hc_ff} + 3'd1;
               hc_in  = 2'd0;
               sl_in  = 3'd0;
            end else if (hc_ff < 2'd3) begin
               wr_en = 1'b1;
               hc_in = hc_ff + 2'd1;
            end
         end else if (b < jse_pkg::CTRL_LIMIT) begin
            body[0] = jse_pkg::CHAR_BACKSLASH;
            body_n  = 3'd2;
            unique case (b)
               jse_pkg::CTRL_LF:  body[1] = jse_pkg::CHAR_N;
               jse_pkg::CTRL_TAB: body[1] = jse_pkg::CHAR_T;
               jse_pkg::CTRL_BS:  body[1] = jse_pkg::CHAR_B;
               jse_pkg::CTRL_FF:  body[1] = jse_pkg::CHAR_F;
               jse_pkg::CTRL_CR:  body[1] = jse_pkg::CHAR_R;
               default: begin
                  body[1] = jse_pkg::CHAR_U;
                  body[2] = jse_pkg::CHAR_ZERO;
                  body[3] = jse_pkg::CHAR_ZERO;
                  body[4] = jse_pkg::hex_char(b[7:4]);
                  body[5] = jse_pkg::hex_char(b[3:0]);
                  body_n  = 3'd6;
               end
            endcase
         end else if (b == jse_pkg::CHAR_BACKSLASH || b == jse_pkg::CHAR_QUOTE) begin
            body[0] = jse_pkg::CHAR_BACKSLASH;
            body[1] = b;
            body_n  = 3'd2;
         end else if (b < jse_pkg::ASCII_LIMIT) begin
            body[0] = b;
            body_n  = 3'd1;
         end else if (lead_n == 3'd0) begin
            disc_in = 1'b1;
         end else begin
            wr_en  = 1'b1;
            wr_idx = 2'd0;
            hc_in  = 2'd1;
            sl_in  = lead_n;
         end
      end
      inside_in = 1'b1;
      if (req_string_end) begin
         inside_in = 1'b0;
         disc_in   = 1'b0;
         hc_in     = 2'd0;
         sl_in     = 3'd0;
      end
   end

   always_comb begin
      logic [2:0] j;
      j = 3'd0;
      for (int i = 0; i < jse_pkg::JOB_BYTES; i++) begin
         j = 3'(i) - {2'b00, open_q};
         if (open_q && i == 0) begin
            job.bytes[i] = jse_pkg::CHAR_QUOTE;
         end else if (j < body_n) begin
            job.bytes[i] = body[j];
         end else begin
            job.bytes[i] = jse_pkg::CHAR_QUOTE;
         end
      end
      job.count = {3'b000, open_q} + {1'b0, body_n} + {3'b000, req_string_end};
      job.last  = req_string_end;
   end

   assign push_job   = job;
   assign push_valid = accept && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         disc_ff   <= 1'b0;
         hc_ff     <= 2'd0;
         sl_ff     <= 3'd0;
      end else if (accept) begin
         inside_ff <= inside_in;
         disc_ff   <= disc_in;
         hc_ff     <= hc_in;
         sl_ff     <= sl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         held_ff[wr_idx] <= b;
      end
   end

   a_pending_counts: assert property (@(posedge clock) disable iff (reset)
      (sl_ff != 3'd0) |-> (hc_ff != 2'd0 && {1'b0, hc_ff} < sl_ff))
      else $error("pending sequence with inconsistent held count");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> (!disc_ff && sl_ff == 3'd0 && hc_ff == 2'd0))
      else $error("state left over outside a string");

endmodule

FILE: hdl/jse_queue.sv
// Short job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module jse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  jse_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output jse_pkg::job_type  pop_job
);

   localparam int PTR_W = (jse_pkg::QUEUE_DEPTH > 1) ? $clog2(jse_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(jse_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(jse_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(jse_pkg::QUEUE_DEPTH);

   jse_pkg::job_type mem_ff [jse_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_nonempty_job: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (pop_job.count != '0))
      else $error("empty job in queue");

endmodule

FILE: hdl/jse_back.sv
// Back end: walks each queued job and drives one output byte per transfer.
`timescale 1ns / 1ps

module jse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  jse_pkg::job_type  pop_job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last
);

   jse_pkg::job_index_type idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;

   assign load   = pop_valid && (!valid_ff || rsp_ready);
   assign at_end = ({1'b0, idx_ff} == (pop_job.count - 1'b1));
   assign pop_ready = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= pop_job.bytes[idx_ff];
         last_ff <= pop_job.last && at_end;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   a_index_in_job: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> ({1'b0, idx_ff} < pop_job.count))
      else $error("job index past job length");

endmodule
